// ===== src/value_rank_assigner_assert.svh =====
// assertion macros used by the port-level checker file
`ifndef VALUE_RANK_ASSIGNER_ASSERT_SVH
`define VALUE_RANK_ASSIGNER_ASSERT_SVH

// concurrent assertion, disabled while reset is low
`define VRA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// concurrent assertion that also holds during reset
`define VRA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/vra_pkg.sv =====
// shared types and constants of the value rank assigner
package vra_pkg;

  localparam int unsigned MaxItems = 64;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned RankW    = 6;
  localparam int unsigned CntW     = $clog2(MaxItems + 1);
  localparam int unsigned IdxW     = $clog2(MaxItems);

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_DRAIN,
    ST_EMIT
  } vra_state_e;

  // control broadcast to every cell
  typedef struct packed {
    logic shift;
    logic clear;
  } vra_ctrl_t;

  // value travelling down the chain with its running count of smaller or equal entries
  typedef struct packed {
    logic                     valid;
    logic signed [ValueW-1:0] key;
    logic [RankW-1:0]         cnt;
  } vra_pass_t;

endpackage

// ===== src/vra_if.sv =====
// valid/ready channels of the value rank assigner
interface vra_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [vra_pkg::ValueW-1:0] value;
  logic                              last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink (input valid, input value, input last_in, output ready);
endinterface

interface vra_out_if;
  logic                       valid;
  logic                       ready;
  logic [vra_pkg::RankW-1:0]  rank;
  logic                       last_out;
  logic                       truncated;

  modport source (output valid, output rank, output last_out, output truncated,
                  input ready);
  modport sink (input valid, input rank, input last_out, input truncated,
                output ready);
endinterface

// ===== src/vra_cell.sv =====
// one slot of the rank chain: stored value, its rank and a forwarding stage
module vra_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vra_pkg::vra_ctrl_t ctrl_i,
  input  vra_pkg::vra_pass_t pass_i,
  output vra_pkg::vra_pass_t pass_o,
  input  logic [vra_pkg::RankW-1:0] rank_i,
  output logic [vra_pkg::RankW-1:0] rank_o
);

  logic                              valid_q;
  logic signed [vra_pkg::ValueW-1:0] key_q;
  logic [vra_pkg::RankW-1:0]         rank_q;
  logic                              pass_valid_q;
  logic signed [vra_pkg::ValueW-1:0] pass_key_q;
  logic [vra_pkg::RankW-1:0]         pass_cnt_q;
  logic                              le;

  // stored value at or below the passing one ranks first (ties by arrival)
  assign le = (key_q <= pass_i.key);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      pass_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        valid_q <= 1'b0;
      end else if (pass_i.valid && !valid_q) begin
        valid_q <= 1'b1;
      end
      pass_valid_q <= pass_i.valid && valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      rank_q <= rank_i;
    end else if (pass_i.valid) begin
      if (!valid_q) begin
        key_q  <= pass_i.key;
        rank_q <= pass_i.cnt;
      end else if (!le) begin
        rank_q <= rank_q + vra_pkg::RankW'(1);
      end
    end
    pass_key_q <= pass_i.key;
    pass_cnt_q <= le ? pass_i.cnt + vra_pkg::RankW'(1) : pass_i.cnt;
  end

  assign pass_o.valid = pass_valid_q;
  assign pass_o.key   = pass_key_q;
  assign pass_o.cnt   = pass_cnt_q;
  assign rank_o       = rank_q;

endmodule

// ===== src/value_rank_assigner.sv =====
// top level of the value rank assigner: cell chain and set sequencer
// Collects a set of signed 32-bit values, one per beat, and returns each
// value's ascending rank in arrival order once the beat marked last_in is
// taken. Input beats are accepted one per cycle while a set is collected.
// Each value walks down a chain of MAX_ITEMS cells, one cell per cycle,
// bumping the rank of every larger stored value and counting the smaller
// or equal ones, and settles in the first empty cell with that count as
// its rank; equal values rank by arrival. After the last beat the block
// waits until no value is still walking the chain, then hands out one rank
// per cycle while the receiver is ready, shifting ranks toward cell 0. A
// set is thus loaded, settled and emitted in turn. Values that arrive with
// the store full are dropped and truncated is set on every result of that
// set. No clearing pass is needed after reset.
module value_rank_assigner (
  input  logic       clk_i,
  input  logic       rst_ni,
  vra_in_if.sink     in_i,
  vra_out_if.source  out_o
);

  vra_pkg::vra_state_e       state_q, state_d;
  logic [vra_pkg::CntW-1:0]  fill_q, fill_d;
  logic [vra_pkg::IdxW-1:0]  emit_q, emit_d;
  logic                      ovf_q, ovf_d;

  logic                      in_acc;
  logic                      out_acc;
  logic                      store;
  logic                      is_last;
  logic                      pipe_busy;
  vra_pkg::vra_ctrl_t        ctrl;

  vra_pkg::vra_pass_t        pass [0:vra_pkg::MaxItems];
  logic [vra_pkg::RankW-1:0] rank [0:vra_pkg::MaxItems];
  logic [vra_pkg::MaxItems-1:0] pipe_valid;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  // drop the value once every cell is claimed
  assign store = in_acc && (fill_q != vra_pkg::CntW'(vra_pkg::MaxItems));

  // feed of the chain
  assign pass[0].valid = store;
  assign pass[0].key   = in_i.value;
  assign pass[0].cnt   = '0;
  assign rank[vra_pkg::MaxItems] = '0;

  for (genvar i = 0; i < vra_pkg::MaxItems; i++) begin : g_cell
    vra_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .pass_i (pass[i]),
      .pass_o (pass[i+1]),
      .rank_i (rank[i+1]),
      .rank_o (rank[i])
    );
    assign pipe_valid[i] = pass[i+1].valid;
  end

  // a value still walking the chain
  assign pipe_busy = |pipe_valid;

  // current slot is the last stored one
  assign is_last = ((vra_pkg::CntW'(emit_q) + vra_pkg::CntW'(1)) == fill_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vra_pkg::ST_COLLECT;
      fill_q  <= '0;
      emit_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      emit_q  <= emit_d;
      ovf_q   <= ovf_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    emit_d      = emit_q;
    ovf_d       = ovf_q;
    ctrl.shift  = 1'b0;
    ctrl.clear  = 1'b0;
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;
    unique case (state_q)
      vra_pkg::ST_COLLECT: begin
        in_i.ready = 1'b1;
        if (store) begin
          fill_d = fill_q + vra_pkg::CntW'(1);
        end else if (in_acc) begin
          ovf_d = 1'b1;
        end
        if (in_acc && in_i.last_in) begin
          state_d = vra_pkg::ST_DRAIN;
        end
      end
      vra_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          state_d = vra_pkg::ST_EMIT;
        end
      end
      vra_pkg::ST_EMIT: begin
        out_o.valid = 1'b1;
        if (out_acc) begin
          ctrl.shift = 1'b1;
          if (is_last) begin
            // end of set: free every cell for the next one
            ctrl.clear = 1'b1;
            fill_d     = '0;
            emit_d     = '0;
            ovf_d      = 1'b0;
            state_d    = vra_pkg::ST_COLLECT;
          end else begin
            emit_d = emit_q + vra_pkg::IdxW'(1);
          end
        end
      end
      default: begin
        state_d = vra_pkg::ST_COLLECT;
      end
    endcase
  end

  // rank and truncated come straight from registers, last_out from a compare of the sequencer counters
  assign out_o.rank      = rank[0];
  assign out_o.last_out  = is_last;
  assign out_o.truncated = ovf_q;

endmodule

// ===== src/vra_checker.sv =====
// port-level checks of the value rank assigner, bound to the top level
`include "value_rank_assigner_assert.svh"

module vra_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_last_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [vra_pkg::RankW-1:0] out_rank_i,
  input logic                      out_last_i,
  input logic                      out_trunc_i
);

  // a stalled result beat holds
  `VRA_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_rank_i) && $stable(out_last_i) && $stable(out_trunc_i), "stalled result changed")

  // no input taken while results are handed out
  `VRA_ASSERT_ALWAYS(a_no_overlap, clk_i, !(out_valid_i && in_ready_i), "input ready during emit")

  // the final beat of a set ends the output burst
  `VRA_ASSERT(a_burst_end, clk_i, rst_ni, out_valid_i && out_ready_i && out_last_i |=> !out_valid_i, "result after last_out")

  // the last value of a set closes the input side
  `VRA_ASSERT(a_set_close, clk_i, rst_ni, in_valid_i && in_ready_i && in_last_i |=> !in_ready_i, "input ready right after last value")

  // truncated is one flag for the whole burst
  `VRA_ASSERT(a_trunc_const, clk_i, rst_ni, out_valid_i && $past(out_valid_i) |-> out_trunc_i == $past(out_trunc_i), "truncated changed within a set")

endmodule

bind value_rank_assigner vra_checker u_vra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_in),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_rank_i  (out_o.rank),
  .out_last_i  (out_o.last_out),
  .out_trunc_i (out_o.truncated)
);

// ===== tb/vra_rank_checker.sv =====
`timescale 1ns / 100ps
// rank predictor and scoreboard watching both channels of the value rank assigner
module vra_rank_checker
  import vra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  vra_in_if           in_ch,
  vra_out_if          out_ch,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned beats_o,
  output int unsigned ranks_o,
  output int unsigned sets_o,
  output int unsigned trunc_sets_o
);

  typedef struct packed {
    logic [RankW-1:0] rank;
    logic             last_out;
    logic             truncated;
  } rank_beat_t;

  // values of the open set in arrival order, with their running ranks
  logic signed [ValueW-1:0] set_values [MaxItems];
  logic [RankW-1:0]         set_ranks  [MaxItems];
  int unsigned              set_fill;
  bit                       set_overflow;
  rank_beat_t               expected_ranks [$];

  function automatic void clear_set();
    foreach (set_ranks[k]) set_ranks[k] = '0;
    set_fill     = 0;
    set_overflow = 1'b0;
  endfunction

  // one accepted value: re-rank the stored ones, release the ranks on last
  function automatic void absorb_value(input logic signed [ValueW-1:0] value,
                                       input logic last_in);
    int unsigned below;
    rank_beat_t  beat;
    below = 0;
    if (set_fill < MaxItems) begin
      for (int unsigned j = 0; j < set_fill; j++) begin
        if (set_values[j] <= value) begin
          below++;
        end else begin
          set_ranks[j] = set_ranks[j] + RankW'(1);
        end
      end
      set_values[set_fill] = value;
      set_ranks[set_fill]  = below[RankW-1:0];
      set_fill++;
    end else begin
      set_overflow = 1'b1;
    end
    if (last_in) begin
      sets_o++;
      if (set_overflow) trunc_sets_o++;
      for (int unsigned k = 0; k < set_fill; k++) begin
        beat.rank      = set_ranks[k];
        beat.last_out  = (k + 1 == set_fill);
        beat.truncated = set_overflow;
        expected_ranks.push_back(beat);
      end
      clear_set();
    end
  endfunction

  function automatic void check_rank(input rank_beat_t got);
    rank_beat_t want;
    if (expected_ranks.size() == 0) begin
      $display("%0t: rank beat with none expected: rank %0d last %b truncated %b",
               $time, got.rank, got.last_out, got.truncated);
      fail_count_o++;
      return;
    end
    want = expected_ranks.pop_front();
    if (got.rank !== want.rank) begin
      $display("%0t: rank mismatch: expected %0d actual %0d", $time, want.rank, got.rank);
      fail_count_o++;
    end
    if (got.last_out !== want.last_out) begin
      $display("%0t: last_out mismatch: expected %b actual %b",
               $time, want.last_out, got.last_out);
      fail_count_o++;
    end
    if (got.truncated !== want.truncated) begin
      $display("%0t: truncated mismatch: expected %b actual %b",
               $time, want.truncated, got.truncated);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_set();
      expected_ranks.delete();
      pending_o = 0;
    end else begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        beats_o++;
        absorb_value(in_ch.value, in_ch.last_in);
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        ranks_o++;
        check_rank(rank_beat_t'{out_ch.rank, out_ch.last_out, out_ch.truncated});
      end
      pending_o = expected_ranks.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// testbench top: stimulus, idling and verdict for the value rank assigner
module tb;
  import vra_pkg::*;

  // long receiver hold-off, well beyond the time to fill the store
  localparam int unsigned HoldCycles = 300;
  // chain settle plus a full emit, waited out at the very end
  localparam int unsigned TailCycles = 2 * MaxItems + 16;
  // far beyond the slowest correct run
  localparam int unsigned TimeoutNs  = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni;

  // idle chances in percent; the receiver's is written only at a rising edge
  int unsigned src_idle_pct = 14;
  int unsigned rx_idle_pct  = 52;
  int unsigned rx_hold_left = 0;
  int unsigned items_sent   = 0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned beats_seen;
  int unsigned ranks_seen;
  int unsigned sets_seen;
  int unsigned trunc_sets;

  vra_in_if  in_ch ();
  vra_out_if out_ch ();

  value_rank_assigner u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // watches both channels, predicts every rank and compares
  vra_rank_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .beats_o      (beats_seen),
    .ranks_o      (ranks_seen),
    .sets_o       (sets_seen),
    .trunc_sets_o (trunc_sets)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random back-pressure, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (rx_hold_left != 0) begin
      out_ch.ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // hard stop in case the block hangs
  initial begin
    #(TimeoutNs);
    $display("simulation failed");
    $finish;
  end

  // mostly random full-range values, with extremes and a narrow band for ties
  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3:    return $urandom_range(15) - 8;
      default: return $urandom;
    endcase
  endfunction

  // mostly small sets, now and then a full store or an overflowing one
  function automatic int unsigned pick_size();
    case ($urandom_range(19))
      0:          return MaxItems;
      1:          return $urandom_range(MaxItems + 6, MaxItems + 1);
      2, 3, 4:    return $urandom_range(40, 13);
      default:    return $urandom_range(12, 1);
    endcase
  endfunction

  // one value beat; called at a falling edge, returns at a falling edge
  // valid is only lowered inside an idle gap, so back-to-back beats keep it high
  task automatic send_beat(input logic signed [ValueW-1:0] value, input logic last_in);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= value;
    in_ch.last_in <= last_in;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic send_set(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_beat(pick_value(), i + 1 == n);
    end
    items_sent += n;
  endtask

  // sender goes quiet until every predicted rank has been delivered
  task automatic wait_for_ranks();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // idle mix changes at a rising edge so the receiver never races the write
  task automatic set_idling(input int unsigned src_pct, input int unsigned rx_pct);
    @(posedge clk_i);
    src_idle_pct = src_pct;
    rx_idle_pct  = rx_pct;
    @(negedge clk_i);
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    in_ch.last_in = 1'b0;
    out_ch.ready  = 1'b0;
    rst_ni        = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes of the value range around zero
    send_beat(32'sh8000_0000, 1'b0);
    send_beat(32'sh7fff_ffff, 1'b0);
    send_beat(32'sh0000_0000, 1'b0);
    send_beat(-32'sd1, 1'b0);
    send_beat(32'sd1, 1'b1);
    // a set of a single value
    send_beat(-32'sd5, 1'b1);
    // equal values rank by arrival
    send_beat(32'sd7, 1'b0);
    send_beat(32'sd7, 1'b0);
    send_beat(-32'sd3, 1'b0);
    send_beat(32'sd7, 1'b1);
    // alternating bit patterns, toggling every value bit
    send_beat(32'sh5555_5555, 1'b0);
    send_beat(32'shaaaa_aaaa, 1'b1);

    // first idling mix: sender idles rarely, receiver often; opens with a store overflow
    send_set($urandom_range(MaxItems + 6, MaxItems + 1));
    while (items_sent < 110) send_set(pick_size());
    wait_for_ranks();

    // second mix: sender idles often, receiver rarely; opens with an exactly full store
    set_idling(52, 14);
    send_set(MaxItems);
    while (items_sent < 220) send_set(pick_size());
    wait_for_ranks();

    // no idling: hold the receiver off while two sets are pushed in,
    // so the store stays occupied and the input has to stall
    set_idling(0, 0);
    @(posedge clk_i);
    rx_hold_left = HoldCycles;
    @(negedge clk_i);
    send_set(20);
    send_set(MaxItems);
    wait_for_ranks();

    while (items_sent < 330) send_set(pick_size());
    wait_for_ranks();

    // let any stray beat show up before the verdict
    repeat (TailCycles) @(negedge clk_i);

    $display("covered %0d value beats in %0d sets, %0d of them truncated",
             beats_seen, sets_seen, trunc_sets);
    $display("checked %0d ranks under three idling mixes and a long receiver hold-off",
             ranks_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
